// ===== rtl/core/gcss_pkg.sv =====
// ----------------------------------------------------------------------------
// gcss_pkg
// Shared types, constants and register codes of the cycle slip screen.
// ----------------------------------------------------------------------------
`default_nettype none

package gcss_pkg;

  // table geometry
  localparam int SATS_PER_SYSTEM = 64;
  localparam int NUM_SYSTEMS     = 4;
  localparam int TABLE_SIZE      = SATS_PER_SYSTEM * NUM_SYSTEMS;
  localparam int IDX_W           = $clog2(TABLE_SIZE);

  // fixed point
  localparam int FRAC_BITS = 16;

  // speed of light in m/s
  localparam logic [28:0] LIGHT_SPEED = 29'd299792458;

  // divider geometry: numerator bits, doubled divisor bits, one step per stage
  localparam int NUM_W     = 112;
  localparam int DEN_W     = 62;
  localparam int DIV_STEPS = NUM_W;

  // register reset values
  localparam logic signed [15:0] ELEV_MASK_RST = 16'sd2560;
  localparam logic [31:0] WIDE_LIMIT_RST  = 32'(64'd7 << (FRAC_BITS - 1));
  localparam logic [31:0] IONO_LIMIT_RST  = 32'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [31:0] IONOC_LIMIT_RST = 32'(64'd7 << (FRAC_BITS - 1));
  localparam logic [31:0] WINDUP_LIMIT_RST = 32'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [46:0] GAP_LIMIT_RST   = 47'(64'd50 << FRAC_BITS);

  localparam logic signed [63:0] SMAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SMIN = {1'b1, {63{1'b0}}};

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ELEV_MASK   = 3'd0,
    CFG_WIDE_LIMIT  = 3'd1,
    CFG_IONO_LIMIT  = 3'd2,
    CFG_IONOC_LIMIT = 3'd3,
    CFG_WINDUP_LIMIT = 3'd4,
    CFG_GAP_LIMIT   = 3'd5
  } cfg_reg_e;

  // reject causes
  typedef enum logic [2:0] {
    CAUSE_OK       = 3'd0,
    CAUSE_MISSING  = 3'd1,
    CAUSE_NO_CORR  = 3'd2,
    CAUSE_ELEV_GAP = 3'd3,
    CAUSE_SLIP     = 3'd4
  } cause_e;

  // raw observation
  typedef struct packed {
    logic [1:0]         cons;
    logic [5:0]         sat;
    logic signed [47:0] l1;
    logic signed [47:0] l2;
    logic [46:0]        c1;
    logic [46:0]        p2;
    logic [30:0]        f1;
    logic [30:0]        f2;
    logic signed [15:0] elev;
    logic signed [31:0] wu;
    logic               corr;
  } obs_t;

  // per item bookkeeping carried down the pipeline
  typedef struct packed {
    logic [1:0]         cons;
    logic [5:0]         sat;
    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic [15:0]        epoch;
    cause_e             cause;
    logic               missing;
    logic signed [48:0] dl;
    logic signed [47:0] gap;
    logic signed [31:0] wu;
    logic               neg_t;
    logic               neg1;
    logic               neg2;
    logic               zero_t;
    logic               zero1;
    logic               zero2;
  } meta_t;

  // one divider lane
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [63:0]      quo;
    logic             sat;
  } div_lane_t;

  // kept entry of one satellite
  typedef struct packed {
    logic [15:0]        tag;
    logic signed [63:0] wide;
    logic signed [63:0] iono;
    logic signed [63:0] ionoc;
    logic signed [31:0] wu;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/gnss_cycle_slip_screen.sv =====
// ----------------------------------------------------------------------------
// gnss_cycle_slip_screen
// Dual-frequency observation screen with per-satellite slip check.
// ----------------------------------------------------------------------------
// Usage: one observation per request enters on the s_axis channel (tuser
// carries the first-of-epoch flag); one result per observation leaves on
// m_axis in the same order (tuser carries keep and the reject cause).
// Limits and the elevation mask are written through the cfg channel, which
// is always ready; write them only while no request is in flight.
// The block is a single pipeline: 7 stages for the products and numerators,
// 113 stages of a radix-2 restoring divider (three lanes side by side, one
// quotient bit per stage), 3 stages of saturating combination, then a table
// read stage and the output register. One request is taken every cycle
// unless a waiting result is held by a low m_axis_tready.
// The satellite table (256 entries) is a memory with registered read; an
// entry kept by the item one stage ahead is forwarded around it.
// Reset clears the epoch counter, all entry valid bits and all stage valid
// bits; the table contents need no clearing.
// When m_axis_tready is low with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated.
`default_nettype none

module gnss_cycle_slip_screen
  import gcss_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: constellation, sat_number, phase_l1, phase_l2, code_c1, code_p2,
  //        freq_one, freq_two, elevation, windup, corrections_ok, zero pad
  input  wire logic [311:0] s_axis_tdata,
  // tuser: first_in_epoch
  input  wire logic         s_axis_tuser,
  // result stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: out_constellation, out_sat_number, wide_combo, iono_combo,
  //        iono_code_combo
  output logic [199:0]      m_axis_tdata,
  // tuser: keep, reject_cause
  output logic [3:0]        m_axis_tuser,
  // configuration writes
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [46:0]  cfg_data_i
);

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic div_lane_t div_step(input div_lane_t l);
    div_lane_t       r;
    logic [DEN_W:0]  rem_sh;
    logic            ge;
    begin
      rem_sh = {l.rem, l.num[NUM_W-1]};
      ge     = rem_sh >= {1'b0, l.den};
      r      = l;
      r.rem  = ge ? DEN_W'(rem_sh - {1'b0, l.den}) : rem_sh[DEN_W-1:0];
      r.sat  = l.sat | l.quo[63];
      r.quo  = {l.quo[62:0], ge};
      r.num  = {l.num[NUM_W-2:0], 1'b0};
      return r;
    end
  endfunction

  function automatic logic signed [63:0] quot_final(input div_lane_t l, input logic neg,
                                                    input logic zero);
    logic signed [63:0] qv;
    begin
      qv = (l.sat || l.quo[63]) ? SMAX : $signed(l.quo);
      if (zero) return 64'sd0;
      return neg ? -qv : qv;
    end
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [65:0] v);
    begin
      if (v[65:63] == 3'b000 || v[65:63] == 3'b111) return v[63:0];
      return v[65] ? SMIN : SMAX;
    end
  endfunction

  function automatic logic jump_over(input logic signed [63:0] a,
                                     input logic signed [63:0] b,
                                     input logic [31:0] limit);
    logic signed [64:0] d;
    logic [64:0]        mag;
    begin
      d   = 65'(a) - 65'(b);
      mag = d[64] ? 65'(-d) : 65'(d);
      return mag > {33'd0, limit};
    end
  endfunction

  // --------------------------------------------------------------------------
  // flow control: the whole pipeline moves together
  // --------------------------------------------------------------------------
  logic advance;
  logic in_acc;
  logic c_valid_q;

  assign advance       = !c_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_acc        = s_axis_tvalid && advance;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [15:0] elev_mask_q;
  logic [31:0]        wide_limit_q;
  logic [31:0]        iono_limit_q;
  logic [31:0]        ionoc_limit_q;
  logic [31:0]        windup_limit_q;
  logic [46:0]        gap_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elev_mask_q    <= ELEV_MASK_RST;
      wide_limit_q   <= WIDE_LIMIT_RST;
      iono_limit_q   <= IONO_LIMIT_RST;
      ionoc_limit_q  <= IONOC_LIMIT_RST;
      windup_limit_q <= WINDUP_LIMIT_RST;
      gap_limit_q    <= GAP_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ELEV_MASK:    elev_mask_q    <= $signed(cfg_data_i[15:0]);
        CFG_WIDE_LIMIT:   wide_limit_q   <= cfg_data_i[31:0];
        CFG_IONO_LIMIT:   iono_limit_q   <= cfg_data_i[31:0];
        CFG_IONOC_LIMIT:  ionoc_limit_q  <= cfg_data_i[31:0];
        CFG_WINDUP_LIMIT: windup_limit_q <= cfg_data_i[31:0];
        CFG_GAP_LIMIT:    gap_limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: input register and epoch count
  // --------------------------------------------------------------------------
  obs_t        in_obs;
  obs_t        s0_q;
  logic        s0_vld_q;
  logic [15:0] epoch_q;
  logic [15:0] epoch_d;
  logic [15:0] s0_epoch_q;

  assign in_obs.cons = s_axis_tdata[1:0];
  assign in_obs.sat  = s_axis_tdata[7:2];
  assign in_obs.l1   = $signed(s_axis_tdata[55:8]);
  assign in_obs.l2   = $signed(s_axis_tdata[103:56]);
  assign in_obs.c1   = s_axis_tdata[150:104];
  assign in_obs.p2   = s_axis_tdata[197:151];
  assign in_obs.f1   = s_axis_tdata[228:198];
  assign in_obs.f2   = s_axis_tdata[259:229];
  assign in_obs.elev = $signed(s_axis_tdata[275:260]);
  assign in_obs.wu   = $signed(s_axis_tdata[307:276]);
  assign in_obs.corr = s_axis_tdata[308];

  assign epoch_d = (in_acc && s_axis_tuser) ? epoch_q + 16'd1 : epoch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q  <= '0;
      s0_vld_q <= 1'b0;
    end else begin
      epoch_q <= epoch_d;
      if (advance) s0_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s0_q       <= in_obs;
      s0_epoch_q <= epoch_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: screening checks, magnitudes and frequency terms
  // --------------------------------------------------------------------------
  meta_t       s1_meta_d;
  meta_t       s1_meta_q;
  logic        s1_vld_q;
  logic [47:0] mag1_d, mag2_d;
  logic [47:0] s1_mag1_q, s1_mag2_q;
  logic [30:0] fd_d, s1_fd_q;
  logic [31:0] fsum_d, s1_fsum_q;
  logic [46:0] s1_c1_q, s1_p2_q;
  logic [30:0] s1_f1_q, s1_f2_q;
  logic        missing;
  logic        in_range;

  always_comb begin
    missing  = (s0_q.l1 == '0) || (s0_q.l2 == '0) || (s0_q.c1 == '0) || (s0_q.p2 == '0);
    in_range = (int'(s0_q.cons) < NUM_SYSTEMS) && (int'(s0_q.sat) < SATS_PER_SYSTEM);

    s1_meta_d.cons     = s0_q.cons;
    s1_meta_d.sat      = s0_q.sat;
    s1_meta_d.in_range = in_range;
    s1_meta_d.idx      = in_range ?
                         IDX_W'(int'(s0_q.cons) * SATS_PER_SYSTEM + int'(s0_q.sat)) : '0;
    s1_meta_d.epoch    = s0_epoch_q;
    s1_meta_d.missing  = missing;
    s1_meta_d.dl       = 49'(s0_q.l1) - 49'(s0_q.l2);
    s1_meta_d.gap      = $signed({1'b0, s0_q.c1}) - $signed({1'b0, s0_q.p2});
    s1_meta_d.wu       = s0_q.wu;
    s1_meta_d.neg_t    = s0_q.f1 < s0_q.f2;
    s1_meta_d.neg1     = s0_q.l1[47];
    s1_meta_d.neg2     = s0_q.l2[47];
    s1_meta_d.zero_t   = (s0_q.f1 == '0) && (s0_q.f2 == '0);
    s1_meta_d.zero1    = s0_q.f1 == '0;
    s1_meta_d.zero2    = s0_q.f2 == '0;

    // lowest failing check wins; slip is decided at the table stage
    if (missing) begin
      s1_meta_d.cause = CAUSE_MISSING;
    end else if (!s0_q.corr) begin
      s1_meta_d.cause = CAUSE_NO_CORR;
    end else if ((s0_q.elev < elev_mask_q) ||
                 (s1_meta_d.gap > $signed({1'b0, gap_limit_q}))) begin
      s1_meta_d.cause = CAUSE_ELEV_GAP;
    end else begin
      s1_meta_d.cause = CAUSE_OK;
    end

    mag1_d = s0_q.l1[47] ? 48'(-s0_q.l1) : 48'(s0_q.l1);
    mag2_d = s0_q.l2[47] ? 48'(-s0_q.l2) : 48'(s0_q.l2);
    fd_d   = (s0_q.f1 < s0_q.f2) ? s0_q.f2 - s0_q.f1 : s0_q.f1 - s0_q.f2;
    fsum_d = 32'(s0_q.f1) + 32'(s0_q.f2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (advance) s1_vld_q <= s0_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_meta_q <= s1_meta_d;
      s1_mag1_q <= mag1_d;
      s1_mag2_q <= mag2_d;
      s1_fd_q   <= fd_d;
      s1_fsum_q <= fsum_d;
      s1_c1_q   <= s0_q.c1;
      s1_p2_q   <= s0_q.p2;
      s1_f1_q   <= s0_q.f1;
      s1_f2_q   <= s0_q.f2;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: partial products
  // --------------------------------------------------------------------------
  meta_t       s2_meta_q;
  logic        s2_vld_q;
  logic [54:0] s2_c1lo_q, s2_p2lo_q;
  logic [53:0] s2_c1hi_q, s2_p2hi_q;
  logic [52:0] s2_m1lo_q, s2_m1hi_q, s2_m2lo_q, s2_m2hi_q;
  logic [60:0] s2_dt_q;
  logic [30:0] s2_fd_q, s2_f1_q, s2_f2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (advance) s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_meta_q <= s1_meta_q;
      s2_c1lo_q <= 55'(s1_c1_q[23:0]) * 55'(s1_f1_q);
      s2_c1hi_q <= 54'(s1_c1_q[46:24]) * 54'(s1_f1_q);
      s2_p2lo_q <= 55'(s1_p2_q[23:0]) * 55'(s1_f2_q);
      s2_p2hi_q <= 54'(s1_p2_q[46:24]) * 54'(s1_f2_q);
      s2_m1lo_q <= 53'(s1_mag1_q[23:0]) * 53'(LIGHT_SPEED);
      s2_m1hi_q <= 53'(s1_mag1_q[47:24]) * 53'(LIGHT_SPEED);
      s2_m2lo_q <= 53'(s1_mag2_q[23:0]) * 53'(LIGHT_SPEED);
      s2_m2hi_q <= 53'(s1_mag2_q[47:24]) * 53'(LIGHT_SPEED);
      s2_dt_q   <= 61'(s1_fsum_q) * 61'(LIGHT_SPEED);
      s2_fd_q   <= s1_fd_q;
      s2_f1_q   <= s1_f1_q;
      s2_f2_q   <= s1_f2_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: assemble full products
  // --------------------------------------------------------------------------
  meta_t       s3_meta_q;
  logic        s3_vld_q;
  logic [77:0] s3_c1f1_q, s3_p2f2_q;
  logic [76:0] s3_l1c_q, s3_l2c_q;
  logic [60:0] s3_dt_q;
  logic [30:0] s3_fd_q, s3_f1_q, s3_f2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else if (advance) s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_meta_q <= s2_meta_q;
      s3_c1f1_q <= (78'(s2_c1hi_q) << 24) + 78'(s2_c1lo_q);
      s3_p2f2_q <= (78'(s2_p2hi_q) << 24) + 78'(s2_p2lo_q);
      s3_l1c_q  <= (77'(s2_m1hi_q) << 24) + 77'(s2_m1lo_q);
      s3_l2c_q  <= (77'(s2_m2hi_q) << 24) + 77'(s2_m2lo_q);
      s3_dt_q   <= s2_dt_q;
      s3_fd_q   <= s2_fd_q;
      s3_f1_q   <= s2_f1_q;
      s3_f2_q   <= s2_f2_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: code sum
  // --------------------------------------------------------------------------
  meta_t       s4_meta_q;
  logic        s4_vld_q;
  logic [78:0] s4_sum_q;
  logic [76:0] s4_l1c_q, s4_l2c_q;
  logic [60:0] s4_dt_q;
  logic [30:0] s4_fd_q, s4_f1_q, s4_f2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else if (advance) s4_vld_q <= s3_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s4_meta_q <= s3_meta_q;
      s4_sum_q  <= 79'(s3_c1f1_q) + 79'(s3_p2f2_q);
      s4_l1c_q  <= s3_l1c_q;
      s4_l2c_q  <= s3_l2c_q;
      s4_dt_q   <= s3_dt_q;
      s4_fd_q   <= s3_fd_q;
      s4_f1_q   <= s3_f1_q;
      s4_f2_q   <= s3_f2_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: frequency difference times code sum, in three slices
  // --------------------------------------------------------------------------
  meta_t       s5_meta_q;
  logic        s5_vld_q;
  logic [57:0] s5_pp0_q, s5_pp1_q;
  logic [55:0] s5_pp2_q;
  logic [76:0] s5_l1c_q, s5_l2c_q;
  logic [60:0] s5_dt_q;
  logic [30:0] s5_f1_q, s5_f2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_vld_q <= 1'b0;
    else if (advance) s5_vld_q <= s4_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s5_meta_q <= s4_meta_q;
      s5_pp0_q  <= 58'(s4_sum_q[26:0]) * 58'(s4_fd_q);
      s5_pp1_q  <= 58'(s4_sum_q[53:27]) * 58'(s4_fd_q);
      s5_pp2_q  <= 56'(s4_sum_q[78:54]) * 56'(s4_fd_q);
      s5_l1c_q  <= s4_l1c_q;
      s5_l2c_q  <= s4_l2c_q;
      s5_dt_q   <= s4_dt_q;
      s5_f1_q   <= s4_f1_q;
      s5_f2_q   <= s4_f2_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: narrow-lane magnitude
  // --------------------------------------------------------------------------
  meta_t        s6_meta_q;
  logic         s6_vld_q;
  logic [109:0] s6_magt_q;
  logic [76:0]  s6_l1c_q, s6_l2c_q;
  logic [60:0]  s6_dt_q;
  logic [30:0]  s6_f1_q, s6_f2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_vld_q <= 1'b0;
    else if (advance) s6_vld_q <= s5_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s6_meta_q <= s5_meta_q;
      s6_magt_q <= 110'(s5_pp0_q) + (110'(s5_pp1_q) << 27) + (110'(s5_pp2_q) << 54);
      s6_l1c_q  <= s5_l1c_q;
      s6_l2c_q  <= s5_l2c_q;
      s6_dt_q   <= s5_dt_q;
      s6_f1_q   <= s5_f1_q;
      s6_f2_q   <= s5_f2_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7 and divider: rounded quotient as floor((2m + d) / 2d)
  // lane 0 narrow-lane term, lane 1 and lane 2 phase ranges
  // --------------------------------------------------------------------------
  div_lane_t div_init [3];
  div_lane_t div_q    [DIV_STEPS+1][3];
  meta_t     div_meta_q [DIV_STEPS+1];
  logic      div_vld_q  [DIV_STEPS+1];

  always_comb begin
    div_init[0].num = NUM_W'({s6_magt_q, 1'b0}) + NUM_W'(s6_dt_q);
    div_init[0].den = DEN_W'({s6_dt_q, 1'b0});
    div_init[1].num = NUM_W'({s6_l1c_q, 1'b0}) + NUM_W'(s6_f1_q);
    div_init[1].den = DEN_W'({s6_f1_q, 1'b0});
    div_init[2].num = NUM_W'({s6_l2c_q, 1'b0}) + NUM_W'(s6_f2_q);
    div_init[2].den = DEN_W'({s6_f2_q, 1'b0});
    for (int l = 0; l < 3; l++) begin
      div_init[l].rem = '0;
      div_init[l].quo = '0;
      div_init[l].sat = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_vld_q[0] <= 1'b0;
    else if (advance) div_vld_q[0] <= s6_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      div_q[0]      <= div_init;
      div_meta_q[0] <= s6_meta_q;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    // one quotient bit per stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) div_vld_q[k+1] <= 1'b0;
      else if (advance) div_vld_q[k+1] <= div_vld_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        div_meta_q[k+1] <= div_meta_q[k];
        for (int l = 0; l < 3; l++) begin
          div_q[k+1][l] <= div_step(div_q[k][l]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // post 1: signed quotients
  // --------------------------------------------------------------------------
  meta_t              p1_meta_q;
  logic               p1_vld_q;
  logic signed [63:0] p1_t_q, p1_t1_q, p1_t2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p1_vld_q <= 1'b0;
    else if (advance) p1_vld_q <= div_vld_q[DIV_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p1_meta_q <= div_meta_q[DIV_STEPS];
      p1_t_q    <= quot_final(div_q[DIV_STEPS][0], div_meta_q[DIV_STEPS].neg_t,
                              div_meta_q[DIV_STEPS].zero_t);
      p1_t1_q   <= quot_final(div_q[DIV_STEPS][1], div_meta_q[DIV_STEPS].neg1,
                              div_meta_q[DIV_STEPS].zero1);
      p1_t2_q   <= quot_final(div_q[DIV_STEPS][2], div_meta_q[DIV_STEPS].neg2,
                              div_meta_q[DIV_STEPS].zero2);
    end
  end

  // --------------------------------------------------------------------------
  // post 2: narrow-lane and phase ionosphere terms
  // --------------------------------------------------------------------------
  meta_t              p2_meta_q;
  logic               p2_vld_q;
  logic signed [63:0] p2_wide_q, p2_iono_q;
  logic signed [63:0] wide_d, iono_d;

  always_comb begin
    wide_d = sat64(66'(p1_t_q) - 66'(p1_meta_q.dl));
    iono_d = sat64(66'(p1_t1_q) - 66'(p1_t2_q));
    if (p1_meta_q.missing) begin
      wide_d = '0;
      iono_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p2_vld_q <= 1'b0;
    else if (advance) p2_vld_q <= p1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p2_meta_q <= p1_meta_q;
      p2_wide_q <= wide_d;
      p2_iono_q <= iono_d;
    end
  end

  // --------------------------------------------------------------------------
  // post 3: phase-plus-code term
  // --------------------------------------------------------------------------
  meta_t              p3_meta_q;
  logic               p3_vld_q;
  logic signed [63:0] p3_wide_q, p3_iono_q, p3_ionoc_q;
  logic signed [63:0] ionoc_d;

  assign ionoc_d = p2_meta_q.missing ? 64'sd0 :
                   sat64(66'(p2_iono_q) + 66'(p2_meta_q.gap));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p3_vld_q <= 1'b0;
    else if (advance) p3_vld_q <= p2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p3_meta_q  <= p2_meta_q;
      p3_wide_q  <= p2_wide_q;
      p3_iono_q  <= p2_iono_q;
      p3_ionoc_q <= ionoc_d;
    end
  end

  // --------------------------------------------------------------------------
  // table stage: registered read, forwarding, slip decision and update
  // --------------------------------------------------------------------------
  entry_t             mem [TABLE_SIZE];
  entry_t             rd_q;
  logic [TABLE_SIZE-1:0] valid_q;

  meta_t              b_meta_q;
  logic               b_vld_q;
  logic signed [63:0] b_wide_q, b_iono_q, b_ionoc_q;

  entry_t             prev;
  entry_t             wr_entry;
  cause_e             cause_d;
  logic               slip;
  logic               wr_en;

  // output register, also the record of the last table write
  logic               c_we_q;
  logic [IDX_W-1:0]   c_idx_q;
  entry_t             c_entry_q;
  cause_e             c_cause_q;
  logic [1:0]         c_cons_q;
  logic [5:0]         c_sat_q;

  always_comb begin
    // the item one stage ahead wrote after this item read
    prev = (c_we_q && c_idx_q == b_meta_q.idx) ? c_entry_q : rd_q;

    slip = b_meta_q.in_range && valid_q[b_meta_q.idx] &&
           (prev.tag == b_meta_q.epoch - 16'd1) &&
           (jump_over(b_wide_q, prev.wide, wide_limit_q) ||
            jump_over(b_iono_q, prev.iono, iono_limit_q) ||
            jump_over(b_ionoc_q, prev.ionoc, ionoc_limit_q) ||
            jump_over(64'(b_meta_q.wu), 64'(prev.wu), windup_limit_q));

    if (b_meta_q.cause != CAUSE_OK) cause_d = b_meta_q.cause;
    else if (slip) cause_d = CAUSE_SLIP;
    else cause_d = CAUSE_OK;

    wr_entry.tag   = b_meta_q.epoch;
    wr_entry.wide  = b_wide_q;
    wr_entry.iono  = b_iono_q;
    wr_entry.ionoc = b_ionoc_q;
    wr_entry.wu    = b_meta_q.wu;

    wr_en = advance && b_vld_q && (cause_d == CAUSE_OK) && b_meta_q.in_range;
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (advance) rd_q <= mem[p3_meta_q.idx];
    if (wr_en) mem[b_meta_q.idx] <= wr_entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      b_vld_q  <= 1'b0;
      c_valid_q <= 1'b0;
      c_we_q   <= 1'b0;
    end else begin
      if (wr_en) valid_q[b_meta_q.idx] <= 1'b1;
      if (advance) begin
        b_vld_q   <= p3_vld_q;
        c_valid_q <= b_vld_q;
        c_we_q    <= wr_en;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_meta_q  <= p3_meta_q;
      b_wide_q  <= p3_wide_q;
      b_iono_q  <= p3_iono_q;
      b_ionoc_q <= p3_ionoc_q;
      c_idx_q   <= b_meta_q.idx;
      c_entry_q <= wr_entry;
      c_cause_q <= cause_d;
      c_cons_q  <= b_meta_q.cons;
      c_sat_q   <= b_meta_q.sat;
    end
  end

  // --------------------------------------------------------------------------
  // result port
  // --------------------------------------------------------------------------
  assign m_axis_tvalid = c_valid_q;
  assign m_axis_tdata  = {c_entry_q.ionoc, c_entry_q.iono, c_entry_q.wide, c_sat_q, c_cons_q};
  assign m_axis_tuser  = {c_cause_q, c_cause_q == CAUSE_OK};

endmodule

`default_nettype wire

// ===== sim/gcss_checker.sv =====
// ----------------------------------------------------------------------------
// gcss_checker
// Watches the request, result and configuration channels of the cycle slip
// screen, predicts every result from its own copy of the satellite table and
// registers, and compares results in order, field by field.
// ----------------------------------------------------------------------------
module gcss_checker
  import gcss_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [311:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [199:0] m_axis_tdata,
  input  logic [3:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [46:0]  cfg_data_i,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               keep;
    cause_e             cause;
    logic [1:0]         cons;
    logic [5:0]         sat;
    logic signed [63:0] wide;
    logic signed [63:0] iono;
    logic signed [63:0] ionoc;
  } screen_res_t;

  // register copy
  logic signed [15:0] elev_mask;
  logic [31:0]        wide_lim, iono_lim, ionoc_lim, wu_lim;
  logic [46:0]        gap_lim;

  // satellite table copy
  logic [15:0] epoch_cnt;
  logic        sat_valid [TABLE_SIZE];
  logic [15:0] sat_tag   [TABLE_SIZE];
  longint      sat_wide  [TABLE_SIZE];
  longint      sat_iono  [TABLE_SIZE];
  longint      sat_ionoc [TABLE_SIZE];
  longint      sat_wu    [TABLE_SIZE];

  screen_res_t expected_q[$];

  // rounded quotient, ties away from zero, saturated magnitude
  function automatic longint rounded_quot(input logic neg, input logic [127:0] mag,
                                          input logic [63:0] den);
    logic [127:0] num, q;
    if (den == 0) return 0;
    num = (mag << 1) + den;
    q = num / ({64'd0, den} << 1);
    if (q > 128'(SMAX)) q = 128'(SMAX);
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // saturating a + b or a - b
  function automatic longint sat_op(input longint a, input longint b, input logic sub);
    logic signed [65:0] x, y;
    x = a;
    y = b;
    x = sub ? x - y : x + y;
    if (x > 66'sd0 + SMAX) return SMAX;
    if (x < -66'sd1 - SMAX) return SMIN;
    return x[63:0];
  endfunction

  // jump of a term against its kept value exceeds the limit
  function automatic logic jumped(input longint a, input longint b, input logic [63:0] lim);
    logic signed [65:0] x;
    x = a;
    x = x - b;
    if (x < 0) x = -x;
    return x > $signed({2'b00, lim});
  endfunction

  // screen one observation and update the table copy
  function automatic screen_res_t screen_obs(input logic first, input logic [311:0] d);
    screen_res_t        r;
    logic [1:0]         cons;
    logic [5:0]         sat;
    longint             l1, l2, wu, t, t1, t2, wide, iono, ionoc;
    logic [46:0]        c1, p2;
    logic [30:0]        f1, f2;
    logic signed [15:0] elev;
    logic               corr, missing, neg, slip;
    logic signed [48:0] gap;
    logic [127:0]       sum;
    logic [63:0]        fd, a1, a2;
    int                 idx;
    cons = d[1:0];
    sat  = d[7:2];
    l1   = $signed(d[55:8]);
    l2   = $signed(d[103:56]);
    c1   = d[150:104];
    p2   = d[197:151];
    f1   = d[228:198];
    f2   = d[259:229];
    elev = d[275:260];
    wu   = $signed(d[307:276]);
    corr = d[308];
    idx  = cons * SATS_PER_SYSTEM + sat;
    gap  = $signed({2'b00, c1}) - $signed({2'b00, p2});
    missing = (l1 == 0) || (l2 == 0) || (c1 == 0) || (p2 == 0);
    wide = 0;
    iono = 0;
    ionoc = 0;
    if (first) epoch_cnt = epoch_cnt + 16'd1;
    // combinations
    if (!missing) begin
      sum = 128'(c1) * 128'(f1) + 128'(p2) * 128'(f2);
      neg = f1 < f2;
      fd = neg ? 64'(f2) - 64'(f1) : 64'(f1) - 64'(f2);
      t = rounded_quot(neg, sum * 128'(fd), (64'(f1) + 64'(f2)) * 64'(LIGHT_SPEED));
      a1 = (l1 < 0) ? -l1 : l1;
      a2 = (l2 < 0) ? -l2 : l2;
      t1 = rounded_quot(l1 < 0, 128'(a1) * 128'(LIGHT_SPEED), 64'(f1));
      t2 = rounded_quot(l2 < 0, 128'(a2) * 128'(LIGHT_SPEED), 64'(f2));
      wide = sat_op(t, l1 - l2, 1'b1);
      iono = sat_op(t1, t2, 1'b1);
      ionoc = sat_op(iono, longint'(gap), 1'b0);
    end
    // slip against the previous epoch entry
    slip = sat_valid[idx] && (sat_tag[idx] == epoch_cnt - 16'd1) &&
           (jumped(wide, sat_wide[idx], 64'(wide_lim)) ||
            jumped(iono, sat_iono[idx], 64'(iono_lim)) ||
            jumped(ionoc, sat_ionoc[idx], 64'(ionoc_lim)) ||
            jumped(wu, sat_wu[idx], 64'(wu_lim)));
    if (missing) r.cause = CAUSE_MISSING;
    else if (!corr) r.cause = CAUSE_NO_CORR;
    else if (elev < elev_mask || gap > $signed({2'b00, gap_lim})) r.cause = CAUSE_ELEV_GAP;
    else if (slip) r.cause = CAUSE_SLIP;
    else r.cause = CAUSE_OK;
    if (r.cause == CAUSE_OK) begin
      sat_valid[idx] = 1'b1;
      sat_tag[idx]   = epoch_cnt;
      sat_wide[idx]  = wide;
      sat_iono[idx]  = iono;
      sat_ionoc[idx] = ionoc;
      sat_wu[idx]    = wu;
    end
    r.keep  = (r.cause == CAUSE_OK);
    r.cons  = cons;
    r.sat   = sat;
    r.wide  = wide;
    r.iono  = iono;
    r.ionoc = ionoc;
    return r;
  endfunction

  // channel monitor, prediction and compare
  always @(posedge clk_i or negedge rst_ni) begin
    screen_res_t exp_r, got_r;
    if (!rst_ni) begin
      elev_mask = ELEV_MASK_RST;
      wide_lim  = WIDE_LIMIT_RST;
      iono_lim  = IONO_LIMIT_RST;
      ionoc_lim = IONOC_LIMIT_RST;
      wu_lim    = WINDUP_LIMIT_RST;
      gap_lim   = GAP_LIMIT_RST;
      epoch_cnt = '0;
      for (int i = 0; i < TABLE_SIZE; i++) sat_valid[i] = 1'b0;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ELEV_MASK:    elev_mask = cfg_data_i[15:0];
          CFG_WIDE_LIMIT:   wide_lim  = cfg_data_i[31:0];
          CFG_IONO_LIMIT:   iono_lim  = cfg_data_i[31:0];
          CFG_IONOC_LIMIT:  ionoc_lim = cfg_data_i[31:0];
          CFG_WINDUP_LIMIT: wu_lim    = cfg_data_i[31:0];
          CFG_GAP_LIMIT:    gap_lim   = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(screen_obs(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.keep  = m_axis_tuser[0];
        got_r.cause = cause_e'(m_axis_tuser[3:1]);
        got_r.cons  = m_axis_tdata[1:0];
        got_r.sat   = m_axis_tdata[7:2];
        got_r.wide  = m_axis_tdata[71:8];
        got_r.iono  = m_axis_tdata[135:72];
        got_r.ionoc = m_axis_tdata[199:136];
        if (expected_q.size() == 0) begin
          $display("%t unexpected result: actual %p", $time, got_r);
          fail_count_o++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got_r.keep != exp_r.keep)
            $display("%t keep: expected %0d actual %0d", $time, exp_r.keep, got_r.keep);
          if (got_r.cause != exp_r.cause)
            $display("%t cause: expected %0d actual %0d", $time, exp_r.cause, got_r.cause);
          if (got_r.cons != exp_r.cons)
            $display("%t constellation: expected %0d actual %0d", $time, exp_r.cons,
                     got_r.cons);
          if (got_r.sat != exp_r.sat)
            $display("%t sat: expected %0d actual %0d", $time, exp_r.sat, got_r.sat);
          if (got_r.wide != exp_r.wide)
            $display("%t wide_combo: expected %0d actual %0d", $time, exp_r.wide,
                     got_r.wide);
          if (got_r.iono != exp_r.iono)
            $display("%t iono_combo: expected %0d actual %0d", $time, exp_r.iono,
                     got_r.iono);
          if (got_r.ionoc != exp_r.ionoc)
            $display("%t iono_code_combo: expected %0d actual %0d", $time, exp_r.ionoc,
                     got_r.ionoc);
          if (got_r != exp_r) fail_count_o++;
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== sim/tb_gnss_cycle_slip_screen.sv =====
// ----------------------------------------------------------------------------
// tb_gnss_cycle_slip_screen
// Drives observations and register writes into the cycle slip screen: a
// directed set of edge cases, then epochs of tracked satellites with small
// noise, jumps, repeats and raw random requests, under several register
// settings, with bursty input, output stalls and one long output hold.
// ----------------------------------------------------------------------------
module tb_gnss_cycle_slip_screen;
  import gcss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 130;
  localparam int POOL = 10;
  localparam logic [30:0] F_L1 = 31'd1575420000;
  localparam logic [30:0] F_L2 = 31'd1227600000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [311:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [46:0]  cfg_data_i = '0;
  int           fail_count, pending;

  // sender pacing and receiver hold request
  int burst_left = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  // tracked satellites
  logic [1:0]         pool_cons [POOL];
  logic [5:0]         pool_sat  [POOL];
  logic signed [47:0] pool_l1   [POOL];
  logic signed [47:0] pool_l2   [POOL];
  logic [46:0]        pool_c1   [POOL];
  logic [46:0]        pool_p2   [POOL];
  logic signed [15:0] pool_elev [POOL];
  logic signed [31:0] pool_wu   [POOL];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  gnss_cycle_slip_screen i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  gcss_checker i_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: changing stall patterns plus one long hold on request
  always @(posedge clk_i) begin
    static int seg = 0, mode = 0, hold = 0;
    if (hold_req && hold == 0) begin
      hold = 300;
      hold_req <= 1'b0;
    end
    if (hold > 0) begin
      hold--;
      m_axis_tready <= 1'b0;
    end else begin
      if (seg == 0) begin
        seg = $urandom_range(20, 200);
        mode = $urandom_range(0, 3);
      end
      seg--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    static int idle = 0;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle = 0;
    else
      idle++;
    if (idle >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [311:0] pack_obs(
      input logic [1:0] cons, input logic [5:0] sat,
      input logic [47:0] l1, input logic [47:0] l2, input logic [46:0] c1,
      input logic [46:0] p2, input logic [30:0] f1, input logic [30:0] f2,
      input logic [15:0] elev, input logic [31:0] wu, input logic corr);
    return {3'b000, corr, wu, elev, f2, f1, p2, c1, l2, l1, sat, cons};
  endfunction

  // one request, with the sender's bursts and gaps
  task automatic send_obs(input logic first, input logic [311:0] d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if (!no_gaps && $urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [46:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // wait for every result, then for the pipeline depth
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_all(input logic [15:0] em, input logic [31:0] wl,
                           input logic [31:0] il, input logic [31:0] cl,
                           input logic [31:0] ul, input logic [46:0] gl);
    cfg_write(CFG_ELEV_MASK, 47'(em));
    cfg_write(CFG_WIDE_LIMIT, 47'(wl));
    cfg_write(CFG_IONO_LIMIT, 47'(il));
    cfg_write(CFG_IONOC_LIMIT, 47'(cl));
    cfg_write(CFG_WINDUP_LIMIT, 47'(ul));
    cfg_write(CFG_GAP_LIMIT, gl);
  endtask

  function automatic logic [46:0] rand47();
    return {$urandom(), $urandom()};
  endfunction

  // tracked satellite with small noise, or a jump in one term
  function automatic logic [311:0] pool_obs(input int k, input logic jump);
    logic signed [47:0] l1, l2;
    logic [46:0]        c1, p2;
    logic signed [31:0] wu;
    l1 = pool_l1[k] + $signed(48'($urandom_range(0, 6))) - 48'sd3;
    l2 = pool_l2[k] + $signed(48'($urandom_range(0, 6))) - 48'sd3;
    c1 = pool_c1[k] + 47'($urandom_range(0, 200));
    p2 = pool_p2[k] + 47'($urandom_range(0, 200));
    wu = pool_wu[k] + $signed(32'($urandom_range(0, 200))) - 32'sd100;
    if (jump) begin
      case ($urandom_range(0, 2))
        0: l1 = l1 + 48'sd1000000;
        1: c1 = c1 + 47'd500000;
        default: wu = wu + 32'sd100000;
      endcase
    end
    return pack_obs(pool_cons[k], pool_sat[k], l1, l2, c1, p2, F_L1, F_L2,
                    pool_elev[k], wu, 1'b1);
  endfunction

  function automatic logic [311:0] noise_obs();
    return pack_obs($urandom(), $urandom(), {$urandom(), $urandom()},
                    {$urandom(), $urandom()}, rand47(), rand47(), $urandom(), $urandom(),
                    16'($signed($urandom_range(0, 46080)) - 23040), $urandom(),
                    $urandom_range(0, 1));
  endfunction

  initial begin
    logic [311:0] nom;
    // tracked satellites: realistic ranges, distinct slots
    for (int k = 0; k < POOL; k++) begin
      pool_cons[k] = k % 4;
      pool_sat[k]  = 6'(k * 5 + 1);
      pool_l1[k]   = 48'sd17592186044416 + $signed(48'($urandom()));
      pool_l2[k]   = 48'sd13000000000000 + $signed(48'($urandom()));
      pool_c1[k]   = 47'd1300000000000 + 47'($urandom());
      pool_p2[k]   = pool_c1[k] + 47'($urandom_range(0, 1 << 20));
      pool_elev[k] = 16'($urandom_range(2600, 23040));
      pool_wu[k]   = $urandom();
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phase 0: default settings written back, directed cases
    write_all(ELEV_MASK_RST, WIDE_LIMIT_RST, IONO_LIMIT_RST, IONOC_LIMIT_RST,
              WINDUP_LIMIT_RST, GAP_LIMIT_RST);
    nom = pool_obs(0, 1'b0);
    send_obs(1'b1, nom);
    send_obs(1'b0, pack_obs(2'd1, 6'd7, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
                            47'h7FFF_FFFF_FFFF, 47'd1, 31'h7FFF_FFFF, 31'd0,
                            16'sd23040, 32'h8000_0000, 1'b1));
    send_obs(1'b0, pack_obs(2'd2, 6'd9, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
                            47'd1, 47'h7FFF_FFFF_FFFF, 31'd0, 31'd0,
                            16'sd23040, 32'h7FFF_FFFF, 1'b1));
    send_obs(1'b0, pack_obs(2'd3, 6'd63, 48'sd1000, -48'sd5000, 47'd77777, 47'd70000,
                            F_L2, F_L1, 16'sd2560, 32'sd0, 1'b1));
    send_obs(1'b0, pack_obs(2'd0, 6'd2, 48'd0, 48'sd5, 47'd6, 47'd6, F_L1, F_L2,
                            16'sd9000, 32'sd0, 1'b1));
    send_obs(1'b0, pack_obs(2'd0, 6'd2, 48'sd5, 48'd0, 47'd6, 47'd6, F_L1, F_L2,
                            16'sd9000, 32'sd0, 1'b0));
    send_obs(1'b0, pack_obs(2'd0, 6'd2, 48'sd5, 48'sd5, 47'd0, 47'd6, F_L1, F_L2,
                            -16'sd23040, 32'sd0, 1'b1));
    send_obs(1'b0, pack_obs(2'd0, 6'd2, 48'sd5, 48'sd5, 47'd6, 47'd0, F_L1, F_L2,
                            16'sd9000, 32'sd0, 1'b1));
    send_obs(1'b0, pack_obs(2'd0, 6'd3, 48'sd5, 48'sd5, 47'd6, 47'd6, F_L1, F_L2,
                            16'sd9000, 32'sd0, 1'b0));
    send_obs(1'b0, pack_obs(2'd0, 6'd3, 48'sd5, 48'sd5, 47'd6, 47'd6, F_L1, F_L2,
                            -16'sd23040, 32'sd0, 1'b1));
    send_obs(1'b0, pack_obs(2'd0, 6'd4, 48'sd5, 48'sd5, 47'd6 + (47'd51 << 16), 47'd6,
                            F_L1, F_L2, 16'sd9000, 32'sd0, 1'b1));
    send_obs(1'b0, pack_obs(2'd0, 6'd4, 48'sd5, 48'sd5, 47'd6 + (47'd50 << 16), 47'd6,
                            F_L1, F_L2, 16'sd2559, 32'sd0, 1'b1));
    send_obs(1'b0, pack_obs(2'd1, 6'd4, 48'sd5, 48'sd5, 47'd1, 47'h7FFF_FFFF_FFFF,
                            F_L1, F_L2, 16'sd9000, 32'sd0, 1'b1));
    // next epoch: small change kept, repeat in the same epoch, then jumps
    send_obs(1'b1, pool_obs(0, 1'b0));
    send_obs(1'b0, pool_obs(0, 1'b1));
    send_obs(1'b0, nom);
    send_obs(1'b1, pool_obs(0, 1'b1));
    send_obs(1'b1, pool_obs(0, 1'b0));
    send_obs(1'b0, pool_obs(0, 1'b0));
    send_obs(1'b1, pool_obs(0, 1'b1));
    settle();

    // random phases under changing register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(16'h8000 | 16'(-23040), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 47'h7FFF_FFFF_FFFF);
        1: write_all(16'sd23040, 32'd0, 32'd0, 32'd0, 32'd0, 47'd0);
        2: write_all(ELEV_MASK_RST, WIDE_LIMIT_RST, IONO_LIMIT_RST, IONOC_LIMIT_RST,
                     WINDUP_LIMIT_RST, GAP_LIMIT_RST);
        3: write_all(-16'sd23040, 32'd40, 32'd3, 32'd300, 32'd150, 47'd1 << 20);
        default: write_all(16'($signed($urandom_range(0, 8000)) - 2000),
                           $urandom_range(10, 1 << 20), $urandom_range(1, 1 << 12),
                           $urandom(), $urandom_range(50, 1 << 16), rand47());
      endcase
      // long output hold with the sender never pausing
      no_gaps = (ph == 2);
      if (ph == 2) hold_req <= 1'b1;
      for (int n = 0; n < 105; ) begin
        int len;
        len = $urandom_range(4, 12);
        for (int j = 0; j < len; j++) begin
          int sel;
          sel = $urandom_range(0, 99);
          if (sel < 70) send_obs(j == 0, pool_obs($urandom_range(0, POOL - 1), 1'b0));
          else if (sel < 80) send_obs(j == 0, pool_obs($urandom_range(0, POOL - 1), 1'b1));
          else send_obs(j == 0, noise_obs());
          n++;
        end
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/gcss_pkg.sv
rtl/core/gnss_cycle_slip_screen.sv
sim/gcss_checker.sv
sim/tb_gnss_cycle_slip_screen.sv
